// ----- design/lpmd_pkg.sv -----
`timescale 1ns / 1ps

package lpmd_pkg;

   localparam int unsigned WORD_BYTES = 4;

   localparam logic [2:0] FIELD_ID     = 3'd0;
   localparam logic [2:0] FIELD_METHOD = 3'd1;
   localparam logic [2:0] FIELD_SOURCE = 3'd2;
   localparam logic [2:0] FIELD_LENGTH = 3'd3;
   localparam logic [2:0] FIELD_BODY   = 3'd4;

   typedef enum logic [4:0] {
      PHASE_ID     = 5'b00001,
      PHASE_METHOD = 5'b00010,
      PHASE_SOURCE = 5'b00100,
      PHASE_LENGTH = 5'b01000,
      PHASE_BODY   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] stream_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  field_code;
      logic [7:0]  byte_value;
      logic [31:0] field_offset;
      logic        header_done;
      logic [31:0] source_word;
      logic [31:0] body_length;
      logic        message_end;
   } rsp_payload_type;

endpackage

// ----- design/lpmd_stream_if.sv -----
`timescale 1ns / 1ps

interface lpmd_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- design/length_prefixed_message_deframer_core.sv -----
`timescale 1ns / 1ps
// The block splits a byte stream of back-to-back length-prefixed messages into tagged fields.
// The request channel carries one stream byte per transfer. The response channel returns
// exactly one transfer per byte with its field code, its offset within the field, and on
// the final header byte the assembled data source and body length. The last byte of a
// message, or the last header byte when the body is empty, carries message_end.
// A header is ID_BYTES identifier bytes, METHOD_BYTES method bytes, a four-byte big-endian
// data source and a four-byte big-endian body length.
// A byte taken at a clock edge is registered and offered as a response after that edge.
// The block takes one byte per cycle while the receiver does not stall, set by the single response register.
// When the receiver stalls, the response register holds its transfer and the request
// channel still takes a byte in any cycle in which the response register is empty or
// drains. Reset returns the parser to the start of an identifier field and empties the
// response register. An incomplete message simply waits for more bytes.
module length_prefixed_message_deframer_core #(
   parameter int unsigned ID_BYTES     = 8,
   parameter int unsigned METHOD_BYTES = 8
) (
   input logic           clock,
   input logic           reset,
   lpmd_stream_if.sink   req_stream,
   lpmd_stream_if.source rsp_stream
);
   import lpmd_pkg::*;

   localparam logic [31:0] ID_LAST     = 32'(ID_BYTES - 1);
   localparam logic [31:0] METHOD_LAST = 32'(METHOD_BYTES - 1);
   localparam logic [31:0] WORD_LAST   = 32'(WORD_BYTES - 1);

   phase_type       phase_ff, phase_in;
   logic [31:0]     offset_ff, offset_in;
   logic [31:0]     source_ff, source_in;
   logic [31:0]     length_ff, length_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            req_accept;
   logic [7:0]      in_byte;
   logic [31:0]     length_next;

   assign in_byte          = req_stream.data.stream_byte;
   assign req_stream.ready = !rsp_valid_ff || rsp_stream.ready;
   assign req_accept       = req_stream.valid && req_stream.ready;
   assign length_next      = {length_ff[23:0], in_byte};

   assign rsp_stream.valid = rsp_valid_ff;
   assign rsp_stream.data  = rsp_data_ff;

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff + 32'd1;
      source_in = source_ff;
      length_in = length_ff;

      rsp_data_in              = '0;
      rsp_data_in.byte_value   = in_byte;
      rsp_data_in.field_offset = offset_ff;

      case (phase_ff)
         PHASE_METHOD: begin
            rsp_data_in.field_code = FIELD_METHOD;
            if (offset_ff >= METHOD_LAST) begin
               source_in = '0;
               phase_in  = PHASE_SOURCE;
               offset_in = '0;
            end
         end
         PHASE_SOURCE: begin
            rsp_data_in.field_code = FIELD_SOURCE;
            source_in              = {source_ff[23:0], in_byte};
            if (offset_ff >= WORD_LAST) begin
               length_in = '0;
               phase_in  = PHASE_LENGTH;
               offset_in = '0;
            end
         end
         PHASE_LENGTH: begin
            rsp_data_in.field_code = FIELD_LENGTH;
            length_in              = length_next;
            if (offset_ff >= WORD_LAST) begin
               rsp_data_in.header_done = 1'b1;
               rsp_data_in.source_word = source_ff;
               rsp_data_in.body_length = length_next;
               offset_in               = '0;
               if (length_next == 32'd0) begin
                  rsp_data_in.message_end = 1'b1;
                  phase_in                = PHASE_ID;
               end else begin
                  phase_in = PHASE_BODY;
               end
            end
         end
         PHASE_BODY: begin
            rsp_data_in.field_code = FIELD_BODY;
            if (length_ff == 32'd0 || offset_ff >= length_ff - 32'd1) begin
               rsp_data_in.message_end = 1'b1;
               phase_in                = PHASE_ID;
               offset_in               = '0;
            end
         end
         default: begin
            rsp_data_in.field_code = FIELD_ID;
            phase_in               = PHASE_ID;
            if (offset_ff >= ID_LAST) begin
               phase_in  = PHASE_METHOD;
               offset_in = '0;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_ID;
         offset_ff    <= '0;
         source_ff    <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff  <= phase_in;
            offset_ff <= offset_in;
            source_ff <= source_in;
            length_ff <= length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   header_done_on_last_length_byte: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.header_done |->
         rsp_data_ff.field_code == FIELD_LENGTH && rsp_data_ff.field_offset == WORD_LAST
   ) else $error("header_done outside the last length byte");

   message_end_placement: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.message_end |->
         rsp_data_ff.field_code == FIELD_BODY || rsp_data_ff.header_done
   ) else $error("message_end on a header byte other than an empty-body header end");

   body_has_length: assert property (
      @(posedge clock) disable iff (reset)
      phase_ff == PHASE_BODY |-> length_ff != 32'd0 && offset_ff < length_ff
   ) else $error("body phase with an exhausted or empty length");

   response_follows_transfer: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept)
   ) else $error("response appeared without an accepted byte");

endmodule
